FILE: src/fbs_pkg.sv
`default_nettype none
package fbs_pkg;

  // Largest source plus repair length of one block
  localparam int MAX_BLOCK_LEN = 64;

  // Field widths
  localparam int BYTES_W = 16;
  localparam int TIME_W  = 32;
  localparam int ID_W    = 6;
  localparam int BNUM_W  = 16;
  localparam int SLEN_W  = 7;
  localparam int RLEN_W  = 6;
  localparam int GAP_W   = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPAIR_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_NUMBER = 2'd2;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_REPAIR
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_source;
    logic load_repair;
    logic next_block;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;
    logic block_ends;
    logic repair_none;
    logic repair_final;
  } status_t;

endpackage
`default_nettype wire

FILE: src/fbs_ctrl.sv
`default_nettype none
module fbs_ctrl
  import fbs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = status.slot_free;
        if (in_valid && status.slot_free) begin
          cmd.load_source = 1'b1;
          if (status.block_ends) begin
            if (status.repair_none) begin
              cmd.next_block = 1'b1;
            end else begin
              state_next = ST_REPAIR;
            end
          end
        end
      end
      ST_REPAIR: begin
        // Emit one repair header per free output slot
        if (status.slot_free) begin
          cmd.load_repair = 1'b1;
          if (status.repair_final) begin
            cmd.next_block = 1'b1;
            state_next     = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/fbs_dp.sv
`default_nettype none
module fbs_dp
  import fbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [BYTES_W-1:0]    in_bytes,
  input  wire logic [TIME_W-1:0]     in_time,
  input  wire cmd_t                  cmd,
  output status_t                    status,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic                       out_is_repair,
  output logic [ID_W-1:0]            out_symbol_id,
  output logic [BNUM_W-1:0]          out_block_number,
  output logic [SLEN_W-1:0]          out_source_len,
  output logic [SLEN_W-1:0]          out_total_len,
  output logic [BYTES_W-1:0]         out_repair_bytes,
  output logic [GAP_W-1:0]           out_max_gap,
  output logic                       out_last
);

  // Configuration registers
  logic [SLEN_W-1:0] source_block_len;
  logic [RLEN_W-1:0] repair_block_len;
  logic [BNUM_W-1:0] start_block_number;

  // Block state
  logic [ID_W-1:0]    position;
  logic [SLEN_W-1:0]  active_src;
  logic [RLEN_W-1:0]  active_rep;
  logic [BNUM_W-1:0]  block_number;
  logic [BYTES_W-1:0] largest;
  logic [TIME_W-1:0]  prev_time;
  logic               prev_valid;
  logic [GAP_W-1:0]   widest;
  logic               started;
  logic [RLEN_W-1:0]  rep_idx;

  // Values in force for the incoming packet
  logic               block_start;
  logic [SLEN_W-1:0]  eff_src;
  logic [RLEN_W-1:0]  eff_rep;
  logic [BYTES_W-1:0] eff_largest;
  logic [TIME_W-1:0]  diff;
  logic               gap_neg;
  logic [GAP_W-1:0]   eff_widest;
  logic               ends;

  // Length pair check for configuration writes
  logic [SLEN_W-1:0] pair_src;
  logic [RLEN_W-1:0] pair_rep;
  logic              pair_ok;
  logic [7:0]        pair_sum;

  assign block_start = (position == '0);
  assign eff_src     = block_start ? source_block_len : active_src;
  assign eff_rep     = block_start ? repair_block_len : active_rep;
  assign eff_largest = (block_start || in_bytes > largest) ? in_bytes : largest;

  // Wrapped gap since the previous block start
  assign diff       = prev_valid ? (in_time - prev_time) : '0;
  assign gap_neg    = diff[TIME_W-1];
  assign eff_widest = (block_start && !gap_neg && diff[GAP_W-1:0] > widest)
                      ? diff[GAP_W-1:0] : widest;

  assign ends = ({1'b0, position} + 7'd1) >= eff_src;

  always_comb begin
    pair_src = source_block_len;
    pair_rep = repair_block_len;
    if (cfg_index == REG_SOURCE_LEN) begin
      pair_src = cfg_data[SLEN_W-1:0];
    end else begin
      pair_rep = cfg_data[RLEN_W-1:0];
    end
    pair_sum = {1'b0, pair_src} + {2'b00, pair_rep};
    pair_ok  = (pair_src != '0) && (pair_sum <= 8'(MAX_BLOCK_LEN))
               && ((pair_src != source_block_len) || (pair_rep != repair_block_len));
  end

  assign status.slot_free    = !out_valid || out_ready;
  assign status.block_ends   = ends;
  assign status.repair_none  = (eff_rep == '0);
  assign status.repair_final = ({1'b0, rep_idx} + 7'd1) == {1'b0, active_rep};

  // Control and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      source_block_len   <= 7'd1;
      repair_block_len   <= '0;
      start_block_number <= '0;
      position           <= '0;
      active_src         <= '0;
      active_rep         <= '0;
      block_number       <= '0;
      largest            <= '0;
      prev_time          <= '0;
      prev_valid         <= 1'b0;
      widest             <= '0;
      started            <= 1'b0;
      rep_idx            <= '0;
      out_valid          <= 1'b0;
    end else begin
      // Hold a beat until taken
      if (cmd.load_source || cmd.load_repair) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.load_source) begin
        started <= 1'b1;
        largest <= eff_largest;
        rep_idx <= '0;
        position <= ends ? '0 : position + 6'd1;
        if (block_start) begin
          active_src <= source_block_len;
          active_rep <= repair_block_len;
          widest     <= eff_widest;
          if (gap_neg) begin
            prev_valid <= 1'b0;
          end else begin
            prev_time  <= in_time;
            prev_valid <= 1'b1;
          end
        end
      end

      if (cmd.load_repair) begin
        rep_idx <= rep_idx + 6'd1;
      end

      if (cmd.next_block) begin
        block_number <= block_number + 16'd1;
      end

      // Configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_SOURCE_LEN, REG_REPAIR_LEN: begin
            if (pair_ok) begin
              source_block_len <= pair_src;
              repair_block_len <= pair_rep;
              prev_valid       <= 1'b0;
            end
          end
          REG_START_NUMBER: begin
            start_block_number <= cfg_data;
            if (!started) begin
              block_number <= cfg_data;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_source) begin
      out_is_repair    <= 1'b0;
      out_symbol_id    <= position;
      out_block_number <= block_number;
      out_source_len   <= eff_src;
      out_total_len    <= eff_src + {1'b0, eff_rep};
      out_repair_bytes <= in_bytes;
      out_max_gap      <= eff_widest;
      out_last         <= ends && (eff_rep == '0);
    end else if (cmd.load_repair) begin
      out_is_repair    <= 1'b1;
      out_symbol_id    <= active_src[ID_W-1:0] + rep_idx;
      out_block_number <= block_number;
      out_source_len   <= active_src;
      out_total_len    <= active_src + {1'b0, active_rep};
      out_repair_bytes <= largest;
      out_max_gap      <= widest;
      out_last         <= status.repair_final;
    end
  end

endmodule
`default_nettype wire

FILE: src/fec_block_sequencer.sv
`default_nettype none
// FEC block sequencer: each source packet beat yields one source header beat;
// the packet that closes a block is followed by one repair header beat per
// repair slot. A source packet is accepted whenever the output register is
// free; after a closing packet with repair slots, the input is held while the
// single output register drains the repair headers, and backpressure on
// m_tready stretches all of this. Length writes take effect
// at the next block start; the start block number applies only before the
// first packet after reset.
module fec_block_sequencer
  import fbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // packet_bytes[15:0], stream_time[47:16]
  input  wire logic [47:0]           s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // symbol_id[5:0], block_number[21:6], source_len_out[28:22],
  // total_len_out[35:29], repair_bytes[51:36], max_gap[82:52], zero[87:83]
  output logic [87:0]                m_tdata,
  // is_repair[0]
  output logic                       m_tuser,
  output logic                       m_tlast
);

  cmd_t    cmd;
  status_t status;

  logic [ID_W-1:0]    symbol_id;
  logic [BNUM_W-1:0]  block_number;
  logic [SLEN_W-1:0]  source_len;
  logic [SLEN_W-1:0]  total_len;
  logic [BYTES_W-1:0] repair_bytes;
  logic [GAP_W-1:0]   max_gap;

  fbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fbs_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_bytes         (s_tdata[15:0]),
    .in_time          (s_tdata[47:16]),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (m_tready),
    .out_valid        (m_tvalid),
    .out_is_repair    (m_tuser),
    .out_symbol_id    (symbol_id),
    .out_block_number (block_number),
    .out_source_len   (source_len),
    .out_total_len    (total_len),
    .out_repair_bytes (repair_bytes),
    .out_max_gap      (max_gap),
    .out_last         (m_tlast)
  );

  // Pack the result beat
  assign m_tdata = {5'b00000, max_gap, repair_bytes, total_len, source_len,
                    block_number, symbol_id};

endmodule
`default_nettype wire

FILE: dv/fbs_checker.sv
module fbs_checker
  import fbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  // packet_bytes[15:0], stream_time[47:16]
  input  wire logic [47:0]           s_tdata,
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  // symbol_id[5:0], block_number[21:6], source_len_out[28:22],
  // total_len_out[35:29], repair_bytes[51:36], max_gap[82:52], zero[87:83]
  input  wire logic [87:0]           m_tdata,
  // is_repair[0]
  input  wire logic                  m_tuser,
  input  wire logic                  m_tlast,
  output int                         errors,
  output int                         pending,
  output int                         checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               is_repair;
    logic [ID_W-1:0]    symbol_id;
    logic [BNUM_W-1:0]  block_number;
    logic [SLEN_W-1:0]  source_len;
    logic [SLEN_W-1:0]  total_len;
    logic [BYTES_W-1:0] repair_bytes;
    logic [GAP_W-1:0]   max_gap;
    logic               last;
  } header_t;

  // Register copies
  logic [SLEN_W-1:0]  src_len_reg;
  logic [RLEN_W-1:0]  rep_len_reg;
  logic [BNUM_W-1:0]  start_num_reg;

  // Sequencer state
  logic [ID_W-1:0]    pos;
  logic [SLEN_W-1:0]  blk_src_len;
  logic [RLEN_W-1:0]  blk_rep_len;
  logic [BNUM_W-1:0]  blk_num;
  logic [BYTES_W-1:0] peak_bytes;
  logic [TIME_W-1:0]  last_start;
  logic               last_start_ok;
  logic [GAP_W-1:0]   widest;
  logic               any_packet;

  header_t header_q[$];

  task report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  // Accept a length pair only if it is legal; a real change drops the gap history
  task set_lengths(input int s, input int r);
    if (s == 0 || s + r > MAX_BLOCK_LEN) return;
    if (s == src_len_reg && r == rep_len_reg) return;
    src_len_reg   = s[SLEN_W-1:0];
    rep_len_reg   = r[RLEN_W-1:0];
    last_start_ok = 1'b0;
  endtask

  task apply_reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SOURCE_LEN: begin
        set_lengths(int'(data[SLEN_W-1:0]), int'(rep_len_reg));
      end
      REG_REPAIR_LEN: begin
        set_lengths(int'(src_len_reg), int'(data[RLEN_W-1:0]));
      end
      REG_START_NUMBER: begin
        start_num_reg = data;
        if (!any_packet) blk_num = data;
      end
      default: ;
    endcase
  endtask

  // Track the widest forward gap between block starts; a backward step breaks the chain
  task note_block_start(input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] diff;
    diff = last_start_ok ? t - last_start : '0;
    if (diff[TIME_W-1]) begin
      last_start_ok = 1'b0;
    end else begin
      if (diff > {1'b0, widest}) widest = diff[GAP_W-1:0];
      last_start    = t;
      last_start_ok = 1'b1;
    end
  endtask

  task push_header(input logic rep, input logic [ID_W-1:0] id,
                   input logic [BYTES_W-1:0] bytes, input logic fin);
    header_t h;
    h.is_repair    = rep;
    h.symbol_id    = id;
    h.block_number = blk_num;
    h.source_len   = blk_src_len;
    h.total_len    = blk_src_len + SLEN_W'(blk_rep_len);
    h.repair_bytes = bytes;
    h.max_gap      = widest;
    h.last         = fin;
    header_q.push_back(h);
  endtask

  task predict_headers(input logic [BYTES_W-1:0] bytes, input logic [TIME_W-1:0] t);
    int  i;
    logic closes;
    any_packet = 1'b1;
    if (pos == '0) begin
      note_block_start(t);
      blk_src_len = src_len_reg;
      blk_rep_len = rep_len_reg;
      peak_bytes  = '0;
    end
    if (bytes > peak_bytes) peak_bytes = bytes;
    closes = (int'(pos) + 1 >= int'(blk_src_len));
    push_header(1'b0, pos, bytes, closes && blk_rep_len == '0);
    pos = pos + 1'b1;
    // Closing packet: queue the repair headers, then advance the block
    if (closes) begin
      for (i = 0; i < int'(blk_rep_len); i++) begin
        push_header(1'b1, ID_W'(int'(blk_src_len) + i), peak_bytes,
                    i + 1 == int'(blk_rep_len));
      end
      blk_num = blk_num + 1'b1;
      pos     = '0;
    end
  endtask

  task check_header();
    header_t got;
    header_t want;
    got.is_repair    = m_tuser;
    got.symbol_id    = m_tdata[5:0];
    got.block_number = m_tdata[21:6];
    got.source_len   = m_tdata[28:22];
    got.total_len    = m_tdata[35:29];
    got.repair_bytes = m_tdata[51:36];
    got.max_gap      = m_tdata[82:52];
    got.last         = m_tlast;
    if (header_q.size() == 0) begin
      report_mismatch($sformatf("header beat %0d arrived with none pending", checked));
    end else begin
      want = header_q.pop_front();
      if (got.is_repair !== want.is_repair)
        report_mismatch($sformatf("beat %0d is_repair %0h, want %0h",
                                  checked, got.is_repair, want.is_repair));
      if (got.symbol_id !== want.symbol_id)
        report_mismatch($sformatf("beat %0d symbol_id %0d, want %0d",
                                  checked, got.symbol_id, want.symbol_id));
      if (got.block_number !== want.block_number)
        report_mismatch($sformatf("beat %0d block_number %0h, want %0h",
                                  checked, got.block_number, want.block_number));
      if (got.source_len !== want.source_len)
        report_mismatch($sformatf("beat %0d source_len %0d, want %0d",
                                  checked, got.source_len, want.source_len));
      if (got.total_len !== want.total_len)
        report_mismatch($sformatf("beat %0d total_len %0d, want %0d",
                                  checked, got.total_len, want.total_len));
      if (got.repair_bytes !== want.repair_bytes)
        report_mismatch($sformatf("beat %0d repair_bytes %0h, want %0h",
                                  checked, got.repair_bytes, want.repair_bytes));
      if (got.max_gap !== want.max_gap)
        report_mismatch($sformatf("beat %0d max_gap %0h, want %0h",
                                  checked, got.max_gap, want.max_gap));
      if (got.last !== want.last)
        report_mismatch($sformatf("beat %0d last %0h, want %0h",
                                  checked, got.last, want.last));
    end
    checked++;
  endtask

  // Watch all three channels on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      src_len_reg   = 1;
      rep_len_reg   = '0;
      start_num_reg = '0;
      pos           = '0;
      blk_src_len   = '0;
      blk_rep_len   = '0;
      blk_num       = '0;
      peak_bytes    = '0;
      last_start    = '0;
      last_start_ok = 1'b0;
      widest        = '0;
      any_packet    = 1'b0;
      header_q.delete();
    end else begin
      if (cfg_we) apply_reg_write(cfg_index, cfg_data);
      if (s_tvalid && s_tready) predict_headers(s_tdata[15:0], s_tdata[47:16]);
      if (m_tvalid && m_tready) check_header();
    end
    pending = header_q.size();
  end

endmodule

FILE: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 400;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [47:0]           s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [87:0]           m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  int errors;
  int pending;
  int checked;
  int cycles = 0;
  int packets_sent = 0;
  int settings_run = 0;
  bit quiet = 1'b0;
  bit long_hold = 1'b0;
  logic [31:0] stamp = '0;

  fec_block_sequencer dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  fbs_checker chk (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .errors(errors), .pending(pending), .checked(checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("watchdog expired after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Header sink: random stalls, one long hold-off on request, none when quiet
  initial begin : sink
    int n;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        n = 0;
        while (n < HOLD_CYCLES) begin
          @(posedge clk);
          n++;
        end
        long_hold = 1'b0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  task reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Clearing repair first makes any legal pair reachable
  task write_lengths(input int s, input int r);
    reg_write(REG_REPAIR_LEN, '0);
    reg_write(REG_SOURCE_LEN, s[CFG_DATA_W-1:0]);
    reg_write(REG_REPAIR_LEN, r[CFG_DATA_W-1:0]);
    settings_run++;
  endtask

  task send_packet(input logic [15:0] bytes, input logic [31:0] t);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {t, bytes};
    do @(posedge clk); while (!s_tready);
    packets_sent++;
  endtask

  // Drop valid and hold until every header has come out
  task drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Mostly forward steps, with occasional wild jumps, near-half-range leaps and backsteps
  function automatic logic [31:0] next_stamp();
    case ($urandom_range(0, 9))
      0: stamp = $urandom;
      1: stamp = stamp + 32'h7000_0000 + $urandom_range(0, 32'h0fff_ffff);
      2: stamp = stamp - $urandom_range(1, 3000);
      default: stamp = stamp + $urandom_range(1, 5000);
    endcase
    return stamp;
  endfunction

  initial begin : stimulus
    int p;
    int s;
    int r;
    int count;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Start number before the first packet, single-packet blocks, gap corners
    reg_write(REG_START_NUMBER, 16'hFFFF);
    cfg_we <= 1'b0;
    send_packet(16'd1, 32'h0000_0000);
    send_packet(16'hFFFF, 32'h7FFF_FFFF);
    send_packet(16'd0, 32'hFFFF_FFFF);
    send_packet(16'h00FF, 32'h0000_0005);
    send_packet(16'h1234, 32'h0000_0003);
    send_packet(16'hFF00, 32'h0000_0010);
    drain();

    // Late start number, unknown index, source length with junk upper bits
    reg_write(REG_START_NUMBER, 16'h1234);
    reg_write(REG_UNUSED, 16'hBEEF);
    reg_write(REG_SOURCE_LEN, 16'hFF83);
    reg_write(REG_REPAIR_LEN, 16'h0002);
    cfg_we <= 1'b0;
    settings_run++;
    stamp = 32'h0000_1000;
    send_packet(16'd10, next_stamp());
    send_packet(16'd60000, next_stamp());
    send_packet(16'd20, next_stamp());
    send_packet(16'd5, next_stamp());
    send_packet(16'd5, next_stamp());
    send_packet(16'd40000, next_stamp());
    drain();

    // Largest repair count, then rejected and unchanged pairs
    write_lengths(1, 63);
    reg_write(REG_SOURCE_LEN, 16'd2);
    reg_write(REG_SOURCE_LEN, 16'd0);
    reg_write(REG_REPAIR_LEN, 16'd63);
    cfg_we <= 1'b0;
    send_packet(16'd777, next_stamp());
    send_packet(16'hFFFF, next_stamp());
    drain();

    // Random phases, each under its own length setting
    for (p = 0; p < 8; p++) begin
      count = 20;
      case (p)
        0: begin s = 64; r = 0;  count = 70; end
        1: begin s = 1;  r = 0;  end
        2: begin s = 32; r = 32; end
        default: begin
          s = int'($urandom_range(1, 12));
          r = int'($urandom_range(0, 12));
        end
      endcase
      reg_write(CFG_IDX_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom));
      reg_write(CFG_IDX_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom));
      write_lengths(s, r);
      if (p == 0) begin
        reg_write(REG_REPAIR_LEN, 16'd1);
        long_hold = 1'b1;
      end
      if (p == 7) quiet = 1'b1;
      cfg_we <= 1'b0;
      repeat (count) send_packet(16'($urandom_range(1, 65535)), next_stamp());
      drain();
    end

    repeat (20) @(posedge clk);
    $display("sent %0d source packets across %0d length settings", packets_sent, settings_run);
    $display("checked %0d header beats, source and repair", checked);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
